[src/lps_pkg.sv]
`timescale 1ns / 1ps

package lps_pkg;

	typedef struct packed {
		logic [1:0]  operation;
		logic [3:0]  led;
		logic [4:0]  position;
		logic [7:0]  symbol;
		logic        symbol_last;
		logic [15:0] loop_limit;
		logic [15:0] step_period;
	} cmd_word_t;

	typedef struct packed {
		logic [3:0] out_led;
		logic [2:0] color;
		logic       run_last;
	} res_word_t;

	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_LOAD = 2'd1;
	localparam logic [1:0] OP_STOP = 2'd2;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_AMBER = 8'h61;
	localparam logic [7:0] CH_GREEN = 8'h67;
	localparam logic [7:0] CH_RED   = 8'h72;
	localparam logic [7:0] CH_ON    = 8'h6F;

	localparam logic [2:0] CODE_OFF     = 3'd0;
	localparam logic [2:0] CODE_AMBER   = 3'd1;
	localparam logic [2:0] CODE_GREEN   = 3'd2;
	localparam logic [2:0] CODE_RED     = 3'd3;
	localparam logic [2:0] CODE_ON      = 3'd4;
	localparam logic [2:0] CODE_UNKNOWN = 3'd7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COPY,
		ST_COMMIT,
		ST_WALK,
		ST_FLUSH
	} state_t;

	function automatic logic [2:0] sym_code(input logic [7:0] ch);
		logic [2:0] c;
		case (ch)
			CH_SPACE: c = CODE_OFF;
			CH_AMBER: c = CODE_AMBER;
			CH_GREEN: c = CODE_GREEN;
			CH_RED:   c = CODE_RED;
			CH_ON:    c = CODE_ON;
			default:  c = CODE_UNKNOWN;
		endcase
		return c;
	endfunction

endpackage

[src/multi_led_pattern_sequencer.sv]
`timescale 1ns / 1ps
// Load word: a load marked last goes on to copy and compare the pattern, one symbol per
// cycle, then commit. Stop word: clears the LED's active flag.
// Tick word: walks the entry memory one LED per cycle while results are not stalled;
// each colour waits in a holding register until the next reporting LED or the end of
// the walk. One word is handled at a time.
// arst_n clears the FSM, active flags, output valid and the shared last colour.
module multi_led_pattern_sequencer #(
	parameter int NUM_LEDS        = 16,
	parameter int MAX_PATTERN_LEN = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  lps_pkg::cmd_word_t  cmd,
	output logic                res_valid,
	input  logic                res_stall,
	output lps_pkg::res_word_t  res
);

	import lps_pkg::*;

	localparam int LW    = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
	localparam int IW    = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
	localparam int LENW  = $clog2(MAX_PATTERN_LEN + 1);
	localparam int ENT_W = LENW + 64 + IW;

	// Per-LED entry packed as {length, limit, period, sub tick, index, loops}.

	state_t state_q, state_d;

	logic accept, adv;
	logic [8:0] pos9;
	logic [6:0] led7;
	logic pos_ok, led_ok;
	logic [IW-1:0] pos_i;
	logic [LW-1:0] led_e;
	logic [LENW-1:0] len_new;

	// memory ports
	logic stg_we, stg_re;
	logic [IW-1:0] stg_raddr;
	logic [2:0] stg_rdata;
	logic st_we, st_re;
	logic [LW+IW-1:0] st_waddr, st_raddr;
	logic [2:0] st_rdata;
	logic ent_we, ent_re;
	logic [LW-1:0] ent_waddr, ent_raddr;
	logic [ENT_W-1:0] ent_wdata, ent_rdata;

	// entry fields as read
	logic [LENW-1:0] r_len;
	logic [15:0] r_lim, r_per, r_sub, r_loops;
	logic [IW-1:0] r_idx;

	// control and pipeline registers
	logic [NUM_LEDS-1:0] active_q;
	logic [LW-1:0] e_q;
	logic [LENW-1:0] len_q, cnt_q;
	logic [15:0] limit_q, period_q;
	logic differ_q;
	logic rdv_s1;
	logic [IW-1:0] ridx_s1;
	logic [LW:0] wcnt_q;
	logic v_s1, v_s2, cv_s2;
	logic [LW-1:0] e_s1, e_s2;
	logic pend_v_q;
	logic [LW-1:0] pend_e_q;
	logic [2:0] pend_col_q, last_q;
	logic res_valid_q;
	res_word_t res_q;

	// walk datapath
	logic finished, report;
	logic [16:0] sub_nx;
	logic wrap, endp;
	logic [LENW:0] idx_nx;
	logic [15:0] u_sub, u_loops;
	logic [IW-1:0] u_idx;
	logic [2:0] c_s2, col_s2;
	logic push, push_last;
	logic [6:0] pend_e7;

	assign accept    = cmd_valid && !cmd_stall;
	assign cmd_stall = (state_q != ST_IDLE);
	assign adv       = !res_valid_q || !res_stall;

	assign pos9    = {4'd0, cmd.position};
	assign led7    = {3'd0, cmd.led};
	assign pos_ok  = pos9 < 9'(MAX_PATTERN_LEN);
	assign led_ok  = led7 < 7'(NUM_LEDS);
	assign pos_i   = pos9[IW-1:0];
	assign led_e   = led7[LW-1:0];
	assign len_new = LENW'(pos9 + 9'd1);

	assign {r_len, r_lim, r_per, r_sub, r_idx, r_loops} = ent_rdata;

	// Advance one LED by one base tick.
	always_comb begin
		finished = (r_lim != 16'd0) && (r_loops >= r_lim);
		report   = v_s1 && active_q[e_s1] && !finished;
		sub_nx   = {1'b0, r_sub} + 17'd1;
		wrap     = sub_nx >= {1'b0, r_per};
		idx_nx   = (LENW+1)'(r_idx) + (LENW+1)'(1);
		endp     = idx_nx >= (LENW+1)'(r_len);
		u_sub    = wrap ? 16'd0 : sub_nx[15:0];
		u_idx    = r_idx;
		u_loops  = r_loops;
		if (wrap) begin
			u_idx = endp ? '0 : idx_nx[IW-1:0];
			if (endp && r_loops != 16'hFFFF) begin
				u_loops = r_loops + 16'd1;
			end
		end
	end

	// Unknown codes repeat the last colour shown.
	assign c_s2   = cv_s2 ? st_rdata : CODE_OFF;
	assign col_s2 = (c_s2 <= CODE_ON) ? c_s2 : last_q;

	always_comb begin
		state_d   = state_q;
		stg_we    = 1'b0;
		stg_re    = 1'b0;
		stg_raddr = cnt_q[IW-1:0];
		st_we     = 1'b0;
		st_waddr  = {e_q, ridx_s1};
		st_re     = 1'b0;
		st_raddr  = {e_q, cnt_q[IW-1:0]};
		ent_we    = 1'b0;
		ent_waddr = e_q;
		ent_wdata = {len_q, limit_q, period_q, 16'd0, {IW{1'b0}}, 16'd0};
		ent_re    = 1'b0;
		ent_raddr = led_e;
		push      = 1'b0;
		push_last = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (cmd.operation)
						OP_LOAD: begin
							if (pos_ok) begin
								stg_we = 1'b1;
								if (cmd.symbol_last && led_ok) begin
									ent_re  = 1'b1;
									state_d = ST_COPY;
								end
							end
						end
						OP_TICK: state_d = ST_WALK;
						default: ;
					endcase
				end
			end
			ST_COPY: begin
				// copy staging into the store while comparing with the old pattern
				if (cnt_q < len_q) begin
					stg_re = 1'b1;
					st_re  = 1'b1;
				end
				st_we = rdv_s1;
				if (cnt_q == len_q && !rdv_s1) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				if (!active_q[e_q]) begin
					ent_we = 1'b1;
				end else if (differ_q || r_len != len_q) begin
					// restart, keep limit and period
					ent_we    = 1'b1;
					ent_wdata = {len_q, r_lim, r_per, 16'd0, {IW{1'b0}}, 16'd0};
				end
				state_d = ST_IDLE;
			end
			ST_WALK: begin
				if (adv) begin
					ent_re    = wcnt_q < (LW+1)'(NUM_LEDS);
					ent_raddr = wcnt_q[LW-1:0];
					ent_we    = report;
					ent_waddr = e_s1;
					ent_wdata = {r_len, r_lim, r_per, u_sub, u_idx, u_loops};
					st_re     = report;
					st_raddr  = {e_s1, r_idx};
					push      = v_s2 && pend_v_q;
					if (wcnt_q == (LW+1)'(NUM_LEDS) && !v_s1 && !v_s2) begin
						state_d = ST_FLUSH;
					end
				end
			end
			ST_FLUSH: begin
				if (adv) begin
					push      = pend_v_q;
					push_last = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= '0;
			rdv_s1      <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			pend_v_q    <= 1'b0;
			last_q      <= CODE_OFF;
			res_valid_q <= 1'b0;
		end else begin
			if (push) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cmd.operation == OP_STOP && led_ok) begin
							active_q[led_e] <= 1'b0;
						end
						rdv_s1   <= 1'b0;
						v_s1     <= 1'b0;
						v_s2     <= 1'b0;
						pend_v_q <= 1'b0;
					end
				end
				ST_COPY: begin
					rdv_s1 <= cnt_q < len_q;
				end
				ST_COMMIT: begin
					active_q[e_q] <= 1'b1;
				end
				ST_WALK: begin
					if (adv) begin
						v_s1 <= wcnt_q < (LW+1)'(NUM_LEDS);
						v_s2 <= report;
						if (v_s2) begin
							pend_v_q <= 1'b1;
							last_q   <= col_s2;
						end
					end
				end
				ST_FLUSH: begin
					if (adv) begin
						pend_v_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	assign pend_e7 = 7'(pend_e_q);

	always_ff @(posedge clk) begin
		if (push) begin
			res_q <= '{out_led: pend_e7[3:0], color: pend_col_q, run_last: push_last};
		end
		case (state_q)
			ST_IDLE: begin
				e_q      <= led_e;
				len_q    <= len_new;
				limit_q  <= cmd.loop_limit;
				period_q <= (cmd.step_period == 16'd0) ? 16'd1 : cmd.step_period;
				cnt_q    <= '0;
				differ_q <= 1'b0;
				wcnt_q   <= '0;
			end
			ST_COPY: begin
				if (cnt_q < len_q) begin
					cnt_q   <= cnt_q + LENW'(1);
					ridx_s1 <= cnt_q[IW-1:0];
				end
				if (rdv_s1 && stg_rdata != st_rdata) begin
					differ_q <= 1'b1;
				end
			end
			ST_WALK: begin
				if (adv) begin
					if (wcnt_q < (LW+1)'(NUM_LEDS)) begin
						wcnt_q <= wcnt_q + (LW+1)'(1);
					end
					e_s1  <= wcnt_q[LW-1:0];
					e_s2  <= e_s1;
					cv_s2 <= (LENW+1)'(r_idx) < (LENW+1)'(r_len);
					if (v_s2) begin
						pend_e_q   <= e_s2;
						pend_col_q <= col_s2;
					end
				end
			end
			default: ;
		endcase
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	lps_ram #(.WIDTH(3), .DEPTH(2 ** IW)) u_staging (
		.clk   (clk),
		.we    (stg_we),
		.waddr (pos_i),
		.wdata (sym_code(cmd.symbol)),
		.re    (stg_re),
		.raddr (stg_raddr),
		.rdata (stg_rdata)
	);

	lps_ram #(.WIDTH(3), .DEPTH(2 ** (LW + IW))) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (stg_rdata),
		.re    (st_re),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	lps_ram #(.WIDTH(ENT_W), .DEPTH(2 ** LW)) u_entry (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.re    (ent_re),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

endmodule

[src/lps_ram.sv]
`timescale 1ns / 1ps

module lps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// hold read data while no read is issued
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
